@@ rtl/ils_pkg.sv @@
// shared types and constants for the indexed list store
package ils_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int CNT_W  = 8;

    localparam logic [DATA_W-1:0] NONE_WORD = '1;

    typedef enum logic [2:0] {
        FUNC_PUSH_FRONT = 3'd0,
        FUNC_PUSH_BACK  = 3'd1,
        FUNC_INSERT     = 3'd2,
        FUNC_POP_FRONT  = 3'd3,
        FUNC_POP_BACK   = 3'd4,
        FUNC_ERASE      = 3'd5,
        FUNC_READ       = 3'd6,
        FUNC_COUNT      = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] word;
    } cell_cmd_t;

endpackage

@@ rtl/indexed_list_store_core.sv @@
// top level of the indexed list store: decode, row of cells, result register
// Bounded ordered list of up to DEPTH (1 to 255) signed 32-bit words, one word per cell in
// a row of cells; front is cell 0. Each request (push front/back, insert before index, pop
// front/back, erase at index, read at index, count) completes in the cycle it is taken: all
// cells shift or hold in parallel from a position compare, and the result (read word or
// -1, count after the operation, status) is registered and presented in the next cycle. A new
// request is taken every cycle while the result register is empty or being drained, so
// the sustained rate is one request per clock. No clearing pass is needed after reset.
module indexed_list_store_core #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[2:0], value[34:3], index[42:35], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], count[39:32], status[41:40], zero pad
);

    localparam int DW = ils_pkg::DATA_W;
    localparam int PW = ils_pkg::POS_W;
    localparam int CW = ils_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    ils_pkg::func_t   func;
    logic [DW-1:0]    value;
    logic [PW-1:0]    index;

    assign func  = ils_pkg::func_t'(s_tdata[2:0]);
    assign value = s_tdata[34:3];
    assign index = s_tdata[42:35];

    logic                 accept;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 m_valid_reg;
    logic [DW-1:0]        rd_reg;
    logic [DW-1:0]        rd_next;
    logic [CW-1:0]        out_count_reg;
    ils_pkg::status_t     status_reg;
    ils_pkg::status_t     status_next;
    ils_pkg::cell_cmd_t   cmd;
    logic [DW-1:0]        cell_data [DEPTH];
    logic [DW-1:0]        cell_tap  [DEPTH];
    logic [DW-1:0]        read_word;
    logic                 full;
    logic                 empty;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = count_reg >= DEPTH_CNT;
    assign empty    = count_reg == '0;

    always_comb
    begin
        read_word = '0;
        for (int i = 0; i < DEPTH; i++)
            read_word = read_word | cell_tap[i];
    end

    always_comb
    begin
        cmd         = '0;
        cmd.word    = value;
        count_next  = count_reg;
        rd_next     = ils_pkg::NONE_WORD;
        status_next = ils_pkg::ST_OK;
        unique case (func)
            ils_pkg::FUNC_PUSH_FRONT, ils_pkg::FUNC_PUSH_BACK, ils_pkg::FUNC_INSERT:
            begin
                unique case (func)
                    ils_pkg::FUNC_PUSH_FRONT: cmd.pos = '0;
                    ils_pkg::FUNC_PUSH_BACK:  cmd.pos = PW'(count_reg);
                    default:                  cmd.pos = index;
                endcase
                if (full)
                    status_next = ils_pkg::ST_FULL;
                else if (cmd.pos > PW'(count_reg))
                    status_next = ils_pkg::ST_RANGE;
                else
                begin
                    cmd.ins    = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            ils_pkg::FUNC_POP_FRONT, ils_pkg::FUNC_POP_BACK, ils_pkg::FUNC_ERASE:
            begin
                unique case (func)
                    ils_pkg::FUNC_POP_FRONT: cmd.pos = '0;
                    ils_pkg::FUNC_POP_BACK:  cmd.pos = PW'(count_reg - CW'(1));
                    default:                 cmd.pos = index;
                endcase
                if (empty)
                    status_next = ils_pkg::ST_EMPTY;
                else if (cmd.pos >= PW'(count_reg))
                    status_next = ils_pkg::ST_RANGE;
                else
                begin
                    cmd.rem    = accept;
                    count_next = count_reg - CW'(1);
                end
            end
            ils_pkg::FUNC_READ:
            begin
                if (empty)
                    status_next = ils_pkg::ST_EMPTY;
                else if (index >= PW'(count_reg))
                    status_next = ils_pkg::ST_RANGE;
                else
                    rd_next = read_word;
            end
            ils_pkg::FUNC_COUNT:
            begin
                status_next = ils_pkg::ST_OK;
            end
            default:
            begin
                status_next = ils_pkg::ST_OK;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DW-1:0] left_d;
        logic [DW-1:0] right_d;
        if (g == 0)
        begin : g_first
            assign left_d = cell_data[0];
        end
        else
        begin : g_mid
            assign left_d = cell_data[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[g];
        end
        else
        begin : g_inner
            assign right_d = cell_data[g+1];
        end

        ils_cell #(
            .IDX(g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .read_pos   (index),
            .data       (cell_data[g]),
            .read_tap   (cell_tap[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg        <= rd_next;
            out_count_reg <= count_next;
            status_reg    <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, status_reg, out_count_reg, rd_reg};

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_CNT)
        else $error("entry count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.rem |=> count_reg == $past(count_reg) - CW'(1))
        else $error("removal did not shrink the list");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && status_reg == ils_pkg::ST_EMPTY |-> out_count_reg == '0)
        else $error("empty status with nonzero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && status_reg != ils_pkg::ST_OK |-> rd_reg == ils_pkg::NONE_WORD)
        else $error("failed request returned a word");

endmodule

@@ rtl/ils_cell.sv @@
// one list position: holds a word, shifts toward either neighbor on insert or erase
module ils_cell #(
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  ils_pkg::cell_cmd_t          cmd,
    input  logic [ils_pkg::DATA_W-1:0]  left_data,
    input  logic [ils_pkg::DATA_W-1:0]  right_data,
    input  logic [ils_pkg::POS_W-1:0]   read_pos,
    output logic [ils_pkg::DATA_W-1:0]  data,
    output logic [ils_pkg::DATA_W-1:0]  read_tap
);

    localparam logic [ils_pkg::POS_W-1:0] CELL_POS = ils_pkg::POS_W'(IDX);

    logic [ils_pkg::DATA_W-1:0] data_reg;
    logic [ils_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (CELL_POS > cmd.pos)
                data_next = left_data;
            else if (CELL_POS == cmd.pos)
                data_next = cmd.word;
        end
        else if (cmd.rem)
        begin
            if (CELL_POS >= cmd.pos)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // zero unless this cell is addressed, so taps can be or-ed together
    assign read_tap = (CELL_POS == read_pos) ? data_reg : '0;

endmodule
